// ----- src/hrrn_pkg.sv -----
package hrrn_pkg;

  localparam int unsigned MAX_PROCS_DEF = 16;

  localparam int unsigned BURST_W = 16;
  localparam int unsigned JOB_W   = 5;
  localparam int unsigned TIME_W  = 20;
  localparam int unsigned NOW_W   = 21;
  localparam int unsigned TOT_W   = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_SCAN
  } ctrl_state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic load;
    logic retire;
    logic now_nz;
  } cell_cmd_t;

  // control part of the candidate that moves down the chain
  typedef struct packed {
    logic tok;
    logic val;
  } hop_ctl_t;

endpackage

// ----- src/hrrn_in_if.sv -----
interface hrrn_in_if;
  import hrrn_pkg::*;

  logic               valid;
  logic               ready;
  logic [BURST_W-1:0] burst_time;
  logic               final_job;

  modport source (output valid, output burst_time, output final_job, input ready);
  modport sink   (input valid, input burst_time, input final_job, output ready);
endinterface

// ----- src/hrrn_out_if.sv -----
interface hrrn_out_if;
  import hrrn_pkg::*;

  logic              valid;
  logic              ready;
  logic [JOB_W-1:0]  job_number;
  logic [TIME_W-1:0] wait_cycles;
  logic [TIME_W-1:0] turnaround;
  logic [TOT_W-1:0]  sum_waiting;
  logic [TOT_W-1:0]  sum_turnaround;
  logic              last_of_run;

  modport source (output valid, output job_number, output wait_cycles, output turnaround,
                  output sum_waiting, output sum_turnaround, output last_of_run,
                  input ready);
  modport sink   (input valid, input job_number, input wait_cycles, input turnaround,
                  input sum_waiting, input sum_turnaround, input last_of_run,
                  output ready);
endinterface

// ----- src/hrrn_batch_scheduler_top.sv -----
// Non-preemptive highest-response-ratio-next scheduler for one batch of up to
// MAX_PROCS jobs, all arriving at time zero. Each input word stores one burst
// in its own cell; the word flagged final_job (or the one that fills the store)
// starts scheduling, and no input is taken until the last result of the batch
// is registered. Every pick passes a candidate down a chain of MAX_PROCS
// cells, one cell per cycle; a pick starts only once the result register is
// free. Ties go to the lowest job number; at time zero the first loaded job
// runs first. Sums are nonzero only on the last_of_run word.
module hrrn_batch_scheduler_top #(
  parameter int unsigned MAX_PROCS = hrrn_pkg::MAX_PROCS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrrn_in_if.sink    in_i,
  hrrn_out_if.source out_o
);
  import hrrn_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_PROCS);

  cell_cmd_t          cmd;
  logic [IDX_W-1:0]   cmd_idx;
  logic [BURST_W-1:0] cmd_burst;

  hop_ctl_t           hop       [0:MAX_PROCS];
  logic [BURST_W-1:0] hop_burst [0:MAX_PROCS];
  logic [IDX_W-1:0]   hop_idx   [0:MAX_PROCS];
  logic [MAX_PROCS-1:0] tok_vec;

  assign hop_burst[0] = '0;
  assign hop_idx[0]   = '0;

  hrrn_ctrl #(
    .MAX_PROCS(MAX_PROCS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_burst_i  (in_i.burst_time),
    .in_final_i  (in_i.final_job),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd),
    .cmd_idx_o   (cmd_idx),
    .cmd_burst_o (cmd_burst),
    .inj_o       (hop[0]),
    .tail_i      (hop[MAX_PROCS]),
    .tail_burst_i(hop_burst[MAX_PROCS]),
    .tail_idx_i  (hop_idx[MAX_PROCS]),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_job_o   (out_o.job_number),
    .out_wait_o  (out_o.wait_cycles),
    .out_turn_o  (out_o.turnaround),
    .out_wsum_o  (out_o.sum_waiting),
    .out_tsum_o  (out_o.sum_turnaround),
    .out_last_o  (out_o.last_of_run)
  );

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    hrrn_cell #(
      .IDX_W (IDX_W),
      .MY_IDX(g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .cmd_idx_i  (cmd_idx),
      .cmd_burst_i(cmd_burst),
      .hop_i      (hop[g]),
      .hop_burst_i(hop_burst[g]),
      .hop_idx_i  (hop_idx[g]),
      .hop_o      (hop[g+1]),
      .hop_burst_o(hop_burst[g+1]),
      .hop_idx_o  (hop_idx[g+1])
    );
    assign tok_vec[g] = hop[g+1].tok;
  end

  // only one scan may be in flight
  a_one_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one scan token in the cell chain");

  // a finished scan always lands in an empty result register
  a_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hop[MAX_PROCS].tok |-> !out_o.valid)
    else $error("scan finished while a result word was still pending");

  // every scan finds an unfinished job
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hop[MAX_PROCS].tok |-> hop[MAX_PROCS].val)
    else $error("scan finished without a candidate");

  // no loading while a batch is being scheduled
  a_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_vec != '0) |-> !in_i.ready)
    else $error("input ready during a scan");

endmodule

// ----- src/hrrn_cell.sv -----
module hrrn_cell #(
  parameter int unsigned IDX_W  = 4,
  parameter int unsigned MY_IDX = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hrrn_pkg::cell_cmd_t         cmd_i,
  input  logic [IDX_W-1:0]            cmd_idx_i,
  input  logic [hrrn_pkg::BURST_W-1:0] cmd_burst_i,
  input  hrrn_pkg::hop_ctl_t          hop_i,
  input  logic [hrrn_pkg::BURST_W-1:0] hop_burst_i,
  input  logic [IDX_W-1:0]            hop_idx_i,
  output hrrn_pkg::hop_ctl_t          hop_o,
  output logic [hrrn_pkg::BURST_W-1:0] hop_burst_o,
  output logic [IDX_W-1:0]            hop_idx_o
);
  import hrrn_pkg::*;

  logic               sel;
  logic               take;
  logic               live_q, live_d;
  logic [BURST_W-1:0] burst_q;
  hop_ctl_t           hop_q, hop_d;
  logic [BURST_W-1:0] hb_q, hb_d;
  logic [IDX_W-1:0]   hi_q, hi_d;

  assign sel = (cmd_idx_i == IDX_W'(MY_IDX));

  // (now+bc)*bb > (now+bb)*bc reduces to now*(bb-bc) > 0
  assign take = hop_i.tok && live_q &&
                (!hop_i.val || (cmd_i.now_nz && (burst_q < hop_burst_i)));

  always_comb begin
    live_d = live_q;
    if (cmd_i.load && sel) begin
      live_d = 1'b1;
    end else if (cmd_i.retire && sel) begin
      live_d = 1'b0;
    end
  end

  always_comb begin
    hop_d.tok = hop_i.tok;
    hop_d.val = hop_i.val | take;
    hb_d      = take ? burst_q : hop_burst_i;
    hi_d      = take ? IDX_W'(MY_IDX) : hop_idx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
      hop_q  <= '0;
    end else begin
      live_q <= live_d;
      hop_q  <= hop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && sel) begin
      burst_q <= cmd_burst_i;
    end
    hb_q <= hb_d;
    hi_q <= hi_d;
  end

  assign hop_o       = hop_q;
  assign hop_burst_o = hb_q;
  assign hop_idx_o   = hi_q;

endmodule

// ----- src/hrrn_ctrl.sv -----
module hrrn_ctrl #(
  parameter int unsigned MAX_PROCS = hrrn_pkg::MAX_PROCS_DEF,
  parameter int unsigned IDX_W     = $clog2(MAX_PROCS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [hrrn_pkg::BURST_W-1:0] in_burst_i,
  input  logic                         in_final_i,
  output logic                         in_ready_o,
  output hrrn_pkg::cell_cmd_t          cmd_o,
  output logic [IDX_W-1:0]             cmd_idx_o,
  output logic [hrrn_pkg::BURST_W-1:0] cmd_burst_o,
  output hrrn_pkg::hop_ctl_t           inj_o,
  input  hrrn_pkg::hop_ctl_t           tail_i,
  input  logic [hrrn_pkg::BURST_W-1:0] tail_burst_i,
  input  logic [IDX_W-1:0]             tail_idx_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [hrrn_pkg::JOB_W-1:0]   out_job_o,
  output logic [hrrn_pkg::TIME_W-1:0]  out_wait_o,
  output logic [hrrn_pkg::TIME_W-1:0]  out_turn_o,
  output logic [hrrn_pkg::TOT_W-1:0]   out_wsum_o,
  output logic [hrrn_pkg::TOT_W-1:0]   out_tsum_o,
  output logic                         out_last_o
);
  import hrrn_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);

  ctrl_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_inc;
  logic [CNT_W-1:0]  pick_q, pick_inc;
  logic [NOW_W-1:0]  now_q, tat;
  logic [TOT_W-1:0]  wtot_q, ttot_q, wtot_nx, ttot_nx;
  logic              in_fire, start, slot_free, tail_fire, last_pick, inject;

  logic              ov_q;
  logic [JOB_W-1:0]  job_q;
  logic [TIME_W-1:0] wait_q, turn_q;
  logic [TOT_W-1:0]  wsum_q, tsum_q;
  logic              last_q;

  assign in_fire   = in_valid_i && in_ready_o;
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign start     = in_fire && (in_final_i || (cnt_inc == CNT_W'(MAX_PROCS)));
  assign slot_free = !ov_q || out_ready_i;
  assign tail_fire = tail_i.tok;
  assign pick_inc  = pick_q + CNT_W'(1);
  assign last_pick = (pick_inc == cnt_q);

  assign tat     = now_q + NOW_W'(tail_burst_i);
  assign wtot_nx = wtot_q + TOT_W'(now_q);
  assign ttot_nx = ttot_q + TOT_W'(tat);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start) state_d = ST_WAIT;
      ST_WAIT: if (slot_free) state_d = ST_SCAN;
      ST_SCAN: if (tail_fire) state_d = last_pick ? ST_IDLE : ST_WAIT;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs: a scan is launched only once the result register will be free
  always_comb begin
    in_ready_o = 1'b0;
    inject     = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_WAIT: inject     = slot_free;
      ST_SCAN: ;
      default: ;
    endcase
  end

  always_comb begin
    cmd_o.load   = in_fire;
    cmd_o.retire = tail_fire;
    cmd_o.now_nz = (now_q != '0);
    cmd_idx_o    = in_fire ? cnt_q[IDX_W-1:0] : tail_idx_i;
    cmd_burst_o  = in_burst_i;
    inj_o.tok    = inject;
    inj_o.val    = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pick_q  <= '0;
      now_q   <= '0;
      wtot_q  <= '0;
      ttot_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        cnt_q <= cnt_inc;
      end
      if (tail_fire) begin
        ov_q <= 1'b1;
        if (last_pick) begin
          cnt_q  <= '0;
          pick_q <= '0;
          now_q  <= '0;
          wtot_q <= '0;
          ttot_q <= '0;
        end else begin
          pick_q <= pick_inc;
          now_q  <= tat;
          wtot_q <= wtot_nx;
          ttot_q <= ttot_nx;
        end
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_fire) begin
      job_q  <= JOB_W'({1'b0, tail_idx_i} + (IDX_W + 1)'(1));
      wait_q <= now_q[TIME_W-1:0];
      turn_q <= tat[TIME_W-1:0];
      wsum_q <= last_pick ? wtot_nx : '0;
      tsum_q <= last_pick ? ttot_nx : '0;
      last_q <= last_pick;
    end
  end

  assign out_valid_o = ov_q;
  assign out_job_o   = job_q;
  assign out_wait_o  = wait_q;
  assign out_turn_o  = turn_q;
  assign out_wsum_o  = wsum_q;
  assign out_tsum_o  = tsum_q;
  assign out_last_o  = last_q;

endmodule

// ----- tb/hrrn_batch_scheduler_checker.sv -----
module hrrn_batch_scheduler_checker
  import hrrn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  hrrn_in_if   in_i,
  hrrn_out_if  out_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PROCS = MAX_PROCS_DEF;

  typedef struct packed {
    logic [JOB_W-1:0]  job;
    logic [TIME_W-1:0] wait_c;
    logic [TIME_W-1:0] tat;
    logic [TOT_W-1:0]  sum_wait;
    logic [TOT_W-1:0]  sum_tat;
    logic              last;
  } sched_word_t;

  sched_word_t        sched_q[$];
  sched_word_t        exp_w;
  sched_word_t        got_w;
  logic [BURST_W-1:0] burst_mem [PROCS];
  int                 loaded;
  int                 err_total;

  initial begin
    loaded       = 0;
    err_total    = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  // exact ratio compare: (now+bc)/bc > (now+bb)/bb, cross-multiplied
  function automatic logic ratio_higher(logic [NOW_W-1:0] now, logic [BURST_W-1:0] bc,
                                        logic [BURST_W-1:0] bb);
    logic [63:0] lhs;
    logic [63:0] rhs;
    lhs = (64'(now) + 64'(bc)) * 64'(bb);
    rhs = (64'(now) + 64'(bb)) * 64'(bc);
    return lhs > rhs;
  endfunction

  task automatic schedule_batch();
    logic [NOW_W-1:0] now;
    logic [NOW_W-1:0] fin;
    logic [TOT_W-1:0] wsum;
    logic [TOT_W-1:0] tsum;
    bit               done [PROCS];
    int               best;
    sched_word_t      w;
    now  = '0;
    wsum = '0;
    tsum = '0;
    foreach (done[i]) done[i] = 1'b0;
    for (int p = 0; p < loaded; p++) begin
      best = -1;
      for (int i = 0; i < loaded; i++) begin
        if (!done[i] && (best < 0 || ratio_higher(now, burst_mem[i], burst_mem[best])))
          best = i;
      end
      fin        = now + NOW_W'(burst_mem[best]);
      done[best] = 1'b1;
      wsum       = wsum + TOT_W'(now);
      tsum       = tsum + TOT_W'(fin);
      w.job      = JOB_W'(best + 1);
      w.wait_c   = now[TIME_W-1:0];
      w.tat      = fin[TIME_W-1:0];
      w.last     = (p == loaded - 1);
      w.sum_wait = w.last ? wsum : '0;
      w.sum_tat  = w.last ? tsum : '0;
      sched_q.push_back(w);
      now = fin;
    end
    loaded = 0;
  endtask

  task automatic check_field(string name, logic [TOT_W-1:0] exp_v, logic [TOT_W-1:0] got_v);
    if (got_v !== exp_v) begin
      err_total++;
      if (err_total <= 10)
        $display("hrrn check: job %0d field %s expected %0d got %0d",
                 exp_w.job, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_i.valid && out_i.ready) begin
        got_w = '{job: out_i.job_number, wait_c: out_i.wait_cycles, tat: out_i.turnaround,
                  sum_wait: out_i.sum_waiting, sum_tat: out_i.sum_turnaround,
                  last: out_i.last_of_run};
        if (sched_q.size() == 0) begin
          err_total++;
          if (err_total <= 10)
            $display("hrrn check: result word with none expected, job %0d wait %0d",
                     got_w.job, got_w.wait_c);
        end else begin
          exp_w = sched_q.pop_front();
          check_field("job_number", TOT_W'(exp_w.job), TOT_W'(got_w.job));
          check_field("wait_cycles", TOT_W'(exp_w.wait_c), TOT_W'(got_w.wait_c));
          check_field("turnaround", TOT_W'(exp_w.tat), TOT_W'(got_w.tat));
          check_field("sum_waiting", exp_w.sum_wait, got_w.sum_wait);
          check_field("sum_turnaround", exp_w.sum_tat, got_w.sum_tat);
          check_field("last_of_run", TOT_W'(exp_w.last), TOT_W'(got_w.last));
        end
      end
      if (in_i.valid && in_i.ready) begin
        burst_mem[loaded] = in_i.burst_time;
        loaded++;
        // a full store starts the batch even without the final flag
        if (in_i.final_job || loaded == PROCS)
          schedule_batch();
      end
    end
    fail_count_o <= err_total;
    pending_o    <= sched_q.size();
  end

endmodule

// ----- tb/hrrn_batch_scheduler_top_test.sv -----
module hrrn_batch_scheduler_top_test;
  import hrrn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PROCS      = MAX_PROCS_DEF;
  localparam int RAND_ITEMS = 500;
  localparam int PHASE_LEN  = 60;
  localparam int CYCLE_CAP  = 2000000;
  localparam int TAIL       = 4 * (PROCS + 1);

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum int {BURSTS_WIDE, BURSTS_NARROW, BURSTS_EXTREME, BURSTS_MIXED} burst_kind_e;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   idle_pct;
  int   stall_pct;
  int   sent_rand;
  logic [BURST_W-1:0] batch_q[$];

  hrrn_in_if  in_ch ();
  hrrn_out_if out_ch ();

  hrrn_batch_scheduler_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  hrrn_batch_scheduler_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("hrrn_batch_scheduler_top: mismatch");
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin idle_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin idle_pct = 79; stall_pct = 0;  end
      IDLE_RECV: begin idle_pct = 0;  stall_pct = 79; end
      default:   begin idle_pct = 13; stall_pct = 13; end
    endcase
  endtask

  task automatic send_word(logic [BURST_W-1:0] b, logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.burst_time <= b;
    in_ch.final_job  <= fin;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_batch(logic fin_last);
    foreach (batch_q[i])
      send_word(batch_q[i], (i == batch_q.size() - 1) ? fin_last : 1'b0);
  endtask

  // hold the input off until every expected result word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [BURST_W-1:0] pick_burst(burst_kind_e kind);
    logic [BURST_W-1:0] b;
    case (kind)
      BURSTS_WIDE:   b = BURST_W'($urandom_range(65535, 1));
      BURSTS_NARROW: b = BURST_W'($urandom_range(8, 1));
      BURSTS_EXTREME: begin
        case ($urandom_range(3))
          0:       b = 16'h0001;
          1:       b = 16'hFFFF;
          2:       b = 16'h5555;
          default: b = 16'hAAAA;
        endcase
      end
      default: b = pick_burst(burst_kind_e'($urandom_range(2)));
    endcase
    return b;
  endfunction

  initial begin
    int          n;
    idle_mode_e  mode;
    idle_mode_e  prev_mode;
    burst_kind_e kind;
    logic        fin;
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.burst_time = '0;
    in_ch.final_job  = 1'b0;
    out_ch.ready     = 1'b0;
    set_idling(IDLE_NONE);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single job, field extremes, ties at time zero, then a batch that fills the store
    batch_q = '{16'h0001};
    send_batch(1'b1);
    batch_q = '{16'hFFFF, 16'h0001};
    send_batch(1'b1);
    batch_q = '{16'd7, 16'd7, 16'd7};
    send_batch(1'b1);
    batch_q = '{16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'd2, 16'd3,
                16'd100, 16'hFFFE, 16'h0001, 16'hFFFF, 16'd4, 16'd4, 16'h00FF, 16'hFF00};
    send_batch(1'b0);
    drain();

    sent_rand = 0;
    prev_mode = IDLE_NONE;
    while (sent_rand < RAND_ITEMS) begin
      mode = idle_mode_e'((sent_rand / PHASE_LEN) % 4);
      if (mode != prev_mode) begin
        drain();
        set_idling(mode);
        prev_mode = mode;
      end
      n    = ($urandom_range(9) == 0) ? PROCS : $urandom_range(PROCS, 1);
      kind = burst_kind_e'($urandom_range(3));
      batch_q.delete();
      repeat (n) batch_q.push_back(pick_burst(kind));
      fin = (n == PROCS) ? 1'($urandom_range(1)) : 1'b1;
      send_batch(fin);
      sent_rand += n;
    end

    drain();
    repeat (TAIL) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("hrrn_batch_scheduler_top: match");
    end else begin
      $display("hrrn_batch_scheduler_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/hrrn_pkg.sv
src/hrrn_in_if.sv
src/hrrn_out_if.sv
src/hrrn_cell.sv
src/hrrn_ctrl.sv
src/hrrn_batch_scheduler_top.sv
tb/hrrn_batch_scheduler_checker.sv
tb/hrrn_batch_scheduler_top_test.sv
